// ===== rtl/xfb_pkg.sv =====
package xfb_pkg;

	// input word: source height and unsigned fixed-point vertical scale (8 fraction bits, 256 = 1.0)
	typedef struct packed {
		logic [9:0] efb_height;
		logic [8:0] scale;
	} xfb_req_t;

	// result word: line count and status code
	typedef struct packed {
		logic [10:0] line_count;
		logic [1:0]  status;
	} xfb_rsp_t;

	// status codes
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_ZERO_HEIGHT = 2'd1;
	localparam logic [1:0] STATUS_ZERO_SCALE  = 2'd2;

	// scale thresholds and saturation limit
	localparam logic [8:0]  FULL_SCALE = 9'h100;
	localparam logic [8:0]  HALF_SCALE = 9'h080;
	localparam logic [10:0] MAX_LINES  = 11'h400;

	// shared divider geometry
	localparam int DVD_W     = 18;
	localparam int DVS_W     = 9;
	localparam int DIV_STEPS = 18;
	localparam int MOD_STEPS = 10;
	localparam int CNT_W     = 5;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_step;
		logic mod_load;
		logic mod_step;
		logic emit;
	} xfb_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic err;
		logic in_range;
	} xfb_stat_t;

endpackage

// ===== rtl/xfb_dp.sv =====
module xfb_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  xfb_pkg::xfb_req_t req,
	input  xfb_pkg::xfb_cmd_t cmd,
	output xfb_pkg::xfb_stat_t stat,
	output xfb_pkg::xfb_rsp_t rsp
);

	logic [9:0]                   height_q;
	logic [8:0]                   scale_q;
	logic [1:0]                   status_q;
	logic [xfb_pkg::DVD_W-1:0]    dvd_q;
	logic [xfb_pkg::DVD_W-1:0]    quo_q;
	logic [xfb_pkg::DVS_W-1:0]    rem_q;
	logic [xfb_pkg::DVS_W-1:0]    dvs_q;
	logic [xfb_pkg::DVS_W-1:0]    odd_q;
	xfb_pkg::xfb_rsp_t            rsp_q;

	logic [xfb_pkg::DVS_W:0]      trial;
	logic                         fits;
	logic [xfb_pkg::DVS_W-1:0]    rem_next;
	logic                         inc;
	logic [xfb_pkg::DVD_W:0]      sum;
	logic [10:0]                  lines;
	logic [1:0]                   status_in;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial    = {rem_q, dvd_q[xfb_pkg::DVD_W-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign rem_next = fits ? xfb_pkg::DVS_W'(trial - {1'b0, dvs_q})
	                       : trial[xfb_pkg::DVS_W-1:0];

	// classify the incoming word
	always_comb begin
		if (req.efb_height == 10'd0) begin
			status_in = xfb_pkg::STATUS_ZERO_HEIGHT;
		end else if (req.scale == 9'd0) begin
			status_in = xfb_pkg::STATUS_ZERO_SCALE;
		end else begin
			status_in = xfb_pkg::STATUS_OK;
		end
	end

	assign stat.err      = status_q != xfb_pkg::STATUS_OK;
	assign stat.in_range = (scale_q > xfb_pkg::HALF_SCALE) && (scale_q < xfb_pkg::FULL_SCALE);

	// add one line, plus one more when the scale is in range and its stripped form divides the height, then saturate
	assign inc   = stat.in_range && (rem_q == '0);
	assign sum   = {1'b0, quo_q} + (xfb_pkg::DVD_W+1)'(1) + (xfb_pkg::DVD_W+1)'(inc);
	assign lines = (sum > (xfb_pkg::DVD_W+1)'(xfb_pkg::MAX_LINES)) ? xfb_pkg::MAX_LINES
	                                                              : sum[10:0];

	// operand and divider registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			height_q <= req.efb_height;
			scale_q  <= req.scale;
			status_q <= status_in;
			dvd_q    <= {req.efb_height - 10'd1, 8'd0};
			rem_q    <= '0;
			dvs_q    <= req.scale;
			odd_q    <= req.scale;
		end else if (cmd.div_step || cmd.mod_step) begin
			dvd_q <= {dvd_q[xfb_pkg::DVD_W-2:0], fits};
			rem_q <= rem_next;
			// strip one trailing zero from the scale per divide step until it is odd
			if (cmd.div_step && odd_q != '0 && !odd_q[0]) begin
				odd_q <= odd_q >> 1;
			end
		end else if (cmd.mod_load) begin
			quo_q <= dvd_q;
			dvd_q <= {height_q, 8'd0};
			rem_q <= '0;
			dvs_q <= odd_q;
		end
	end

	// register the result word on emit; it holds until the next emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else if (cmd.emit) begin
			if (stat.err) begin
				rsp_q.line_count <= '0;
			end else begin
				rsp_q.line_count <= lines;
			end
			rsp_q.status <= status_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/xfb_ctrl.sv =====
module xfb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  xfb_pkg::xfb_stat_t stat,
	output xfb_pkg::xfb_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MODL,
		ST_MOD,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic [xfb_pkg::CNT_W-1:0] cnt_q;
	logic                      done_q;

	assign busy = state_q != ST_IDLE;
	assign done = done_q;

	// decode commands from the current state
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.div_step = (state_q == ST_DIV) && !stat.err;
		cmd.mod_load = state_q == ST_MODL;
		cmd.mod_step = state_q == ST_MOD;
		cmd.emit     = state_q == ST_EMIT;
	end

	// advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (stat.err) begin
						state_q <= ST_EMIT;
					end else if (cnt_q == xfb_pkg::CNT_W'(xfb_pkg::DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_MODL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MODL: begin
					if (stat.in_range) begin
						state_q <= ST_MOD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_MOD: begin
					if (cnt_q == xfb_pkg::CNT_W'(xfb_pkg::MOD_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/xfb_line_count.sv =====
// Each word is loaded and divided, then the remainder pass is loaded; it runs only for a
// scale in (128, 256) before emit. A zero height or zero scale goes straight to emit.
// A new word is taken only while idle, not while one is in flight; the shared
// one-bit-per-cycle restoring divider serves both (18 quotient, 10 height remainder steps).
// done is high for one cycle with the result; the receiver cannot stall.
// Reset (arst_n low) returns the controller to idle and drops done; no results pending.
module xfb_line_count (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  xfb_pkg::xfb_req_t req,
	output logic              busy,
	output logic              done,
	output xfb_pkg::xfb_rsp_t rsp
);

	xfb_pkg::xfb_cmd_t  cmd;
	xfb_pkg::xfb_stat_t stat;

	// sequence the divide and remainder passes
	xfb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// operands, shared divider and result register
	xfb_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
